/* hdl/ray_box_slab_test_assert.svh */
`ifndef RAY_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_ASSERT_SVH

// Check that a condition implies a consequent in the same cycle, out of reset.
`define RBST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_box_slab_test check failed");

// Check that a condition implies a consequent in the next cycle, out of reset.
`define RBST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_box_slab_test check failed");

`endif

/* hdl/rbst_pkg.sv */
package rbst_pkg;

    // Coordinate and time width, Q16.16
    localparam int T_W    = 32;
    localparam int FRAC_W = 16;
    localparam int EPS_W  = 16;
    // Exact difference of two coordinates
    localparam int DIFF_W = T_W + 1;
    localparam int ENTRY_W = T_W - 1;
    localparam int AXES   = 3;

    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

    // Per-item control that travels beside the dividers
    typedef struct packed {
        logic             valid;
        logic [AXES-1:0]  active;
        logic [AXES-1:0]  inslab;
    } side_t;

endpackage

/* hdl/rbst_div.sv */
module rbst_div (
    input  logic                        clk,
    input  logic [rbst_pkg::DIFF_W-1:0] num_mag,
    input  logic [rbst_pkg::T_W-1:0]    den,
    input  logic                        neg,
    output logic [rbst_pkg::T_W-1:0]    quo
);
    import rbst_pkg::*;

    // One quotient bit per stage, quotient bits DIFF_W-1 down to 0
    localparam int QB = DIFF_W;
    localparam int HI_W = T_W - FRAC_W;

    logic [T_W-1:0] rem_reg [0:QB-1];
    logic [QB-1:0]  nlo_reg [0:QB-1];
    logic [QB-1:0]  quo_reg [0:QB];
    logic [T_W-1:0] den_reg [0:QB-1];
    logic           neg_reg [0:QB];
    logic           ovf_reg [0:QB];
    logic [T_W-1:0] quo_reg_out;
    logic [T_W-1:0] quo_next;

    // Load the high numerator bits and flag quotients of 2^33 or more
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(T_W-HI_W){1'b0}}, num_mag[DIFF_W-1 -: HI_W]};
        nlo_reg[0] <= {num_mag[DIFF_W-HI_W-1:0], {FRAC_W{1'b0}}};
        quo_reg[0] <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= neg;
        ovf_reg[0] <= ({{(T_W-HI_W){1'b0}}, num_mag[DIFF_W-1 -: HI_W]} >= den);
    end

    // Restoring division, one compare and subtract per stage
    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [T_W:0] trial;
        logic [T_W:0] sub;
        logic         ge;

        always_comb
        begin
            trial = {rem_reg[i-1], nlo_reg[i-1][QB-1]};
            sub   = trial - {1'b0, den_reg[i-1]};
            ge    = (trial >= {1'b0, den_reg[i-1]});
        end

        always_ff @(posedge clk)
        begin
            quo_reg[i] <= {quo_reg[i-1][QB-2:0], ge};
            neg_reg[i] <= neg_reg[i-1];
            ovf_reg[i] <= ovf_reg[i-1];
        end

        if (i < QB)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                nlo_reg[i] <= {nlo_reg[i-1][QB-2:0], 1'b0};
                rem_reg[i] <= ge ? sub[T_W-1:0] : trial[T_W-1:0];
                den_reg[i] <= den_reg[i-1];
            end
        end
    end

    // Saturate to the signed range and apply the sign
    always_comb
    begin
        if (ovf_reg[QB] || (quo_reg[QB][QB-1:T_W-1] != '0))
            quo_next = neg_reg[QB] ? T_MIN : T_MAX;
        else if (neg_reg[QB])
            quo_next = T_W'(-quo_reg[QB][T_W-1:0]);
        else
            quo_next = quo_reg[QB][T_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        quo_reg_out <= quo_next;
    end

    assign quo = quo_reg_out;

endmodule

/* hdl/ray_box_slab_test.sv */
// Ray versus axis-aligned box slab test, signed Q16.16 throughout.
// Input channel: drive the twelve coordinate ports and pulse start; the
// transaction is taken at a rising edge with start high and busy low.
// busy is high only while reset is applied and until the first rising edge after it,
// so a new ray can be issued every cycle.
// Result channel: strobe is high for exactly one cycle with hit and
// entry_time; the receiver takes it at that edge and cannot stall it.
// Throughput: one test per cycle. The pipeline consists of input and setup
// stages, six pipelined restoring dividers of 35 stages each (load, one
// quotient bit per stage for 33 stages, output), then slab ordering and
// interval compare stages.
// Configuration: write epsilon (16 bits) on cfg_valid/cfg_ready while no
// test is in flight; cfg_ready is high whenever busy is low.
// Reset: clears all valid bits so no stale result appears, and sets
// epsilon to 1.
module ray_box_slab_test (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rbst_pkg::EPS_W-1:0]    cfg_data,
    input  logic [rbst_pkg::T_W-1:0]      origin_x,
    input  logic [rbst_pkg::T_W-1:0]      origin_y,
    input  logic [rbst_pkg::T_W-1:0]      origin_z,
    input  logic [rbst_pkg::T_W-1:0]      dir_x,
    input  logic [rbst_pkg::T_W-1:0]      dir_y,
    input  logic [rbst_pkg::T_W-1:0]      dir_z,
    input  logic [rbst_pkg::T_W-1:0]      box_x_min,
    input  logic [rbst_pkg::T_W-1:0]      box_x_max,
    input  logic [rbst_pkg::T_W-1:0]      box_y_min,
    input  logic [rbst_pkg::T_W-1:0]      box_y_max,
    input  logic [rbst_pkg::T_W-1:0]      box_z_min,
    input  logic [rbst_pkg::T_W-1:0]      box_z_max,
    output logic                          strobe,
    output logic                          hit,
    output logic [rbst_pkg::ENTRY_W-1:0]  entry_time
);
    import rbst_pkg::*;

    // Divider latency from its input registers to its output register
    localparam int DIV_LAT = DIFF_W + 2;

    logic                  busy_reg;
    logic [EPS_W-1:0]      eps_reg;

    logic                  va_reg;
    logic signed [T_W-1:0] org_a_reg  [AXES];
    logic signed [T_W-1:0] dir_a_reg  [AXES];
    logic signed [T_W-1:0] bmin_a_reg [AXES];
    logic signed [T_W-1:0] bmax_a_reg [AXES];

    logic [DIFF_W-1:0]     nmin_b_reg [AXES];
    logic [DIFF_W-1:0]     nmax_b_reg [AXES];
    logic                  smin_b_reg [AXES];
    logic                  smax_b_reg [AXES];
    logic [T_W-1:0]        den_b_reg  [AXES];
    logic [AXES-1:0]       active_b;
    logic [AXES-1:0]       inslab_b;
    side_t                 side_b_next;
    side_t                 side_reg   [0:DIV_LAT];

    logic signed [T_W-1:0] qmin       [AXES];
    logic signed [T_W-1:0] qmax       [AXES];

    logic signed [T_W-1:0] lo_c_reg   [AXES];
    logic signed [T_W-1:0] hi_c_reg   [AXES];
    logic                  vc_reg;
    logic                  okc_reg;

    logic signed [T_W-1:0] lo_d;
    logic signed [T_W-1:0] hi_d;
    logic                  hit_next;
    logic                  strobe_reg;
    logic                  hit_reg;
    logic [ENTRY_W-1:0]    entry_reg;

    // Busy only around reset; epsilon register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            eps_reg  <= EPS_W'(1);
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                eps_reg <= cfg_data;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    // Capture the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start && !busy_reg;
    end

    always_ff @(posedge clk)
    begin
        org_a_reg[0]  <= origin_x;
        org_a_reg[1]  <= origin_y;
        org_a_reg[2]  <= origin_z;
        dir_a_reg[0]  <= dir_x;
        dir_a_reg[1]  <= dir_y;
        dir_a_reg[2]  <= dir_z;
        bmin_a_reg[0] <= box_x_min;
        bmax_a_reg[0] <= box_x_max;
        bmin_a_reg[1] <= box_y_min;
        bmax_a_reg[1] <= box_y_max;
        bmin_a_reg[2] <= box_z_min;
        bmax_a_reg[2] <= box_z_max;
    end

    // Setup: slab differences, magnitudes, signs and near-zero tests
    for (genvar a = 0; a < AXES; a++)
    begin : g_setup
        logic signed [DIFF_W-1:0] dmin;
        logic signed [DIFF_W-1:0] dmax;
        logic [T_W-1:0]           mag;
        logic signed [DIFF_W:0]   lim_lo;
        logic signed [DIFF_W:0]   lim_hi;
        logic signed [DIFF_W:0]   org_w;
        logic                     act;
        logic                     ins;

        always_comb
        begin
            dmin   = DIFF_W'(bmin_a_reg[a]) - DIFF_W'(org_a_reg[a]);
            dmax   = DIFF_W'(bmax_a_reg[a]) - DIFF_W'(org_a_reg[a]);
            mag    = dir_a_reg[a][T_W-1] ? T_W'(-dir_a_reg[a]) : dir_a_reg[a];
            org_w  = (DIFF_W+1)'(org_a_reg[a]);
            lim_lo = (DIFF_W+1)'(bmin_a_reg[a]) - $signed({2'b00, eps_reg});
            lim_hi = (DIFF_W+1)'(bmax_a_reg[a]) + $signed({2'b00, eps_reg});
            act    = (mag > T_W'(eps_reg));
            ins    = (org_w >= lim_lo) && (org_w <= lim_hi);
        end

        assign active_b[a] = act;
        assign inslab_b[a] = ins;

        always_ff @(posedge clk)
        begin
            nmin_b_reg[a] <= dmin[DIFF_W-1] ? DIFF_W'(-dmin) : dmin;
            nmax_b_reg[a] <= dmax[DIFF_W-1] ? DIFF_W'(-dmax) : dmax;
            smin_b_reg[a] <= dmin[DIFF_W-1] ^ dir_a_reg[a][T_W-1];
            smax_b_reg[a] <= dmax[DIFF_W-1] ^ dir_a_reg[a][T_W-1];
            den_b_reg[a]  <= mag;
        end

        rbst_div u_div_min (
            .clk     (clk),
            .num_mag (nmin_b_reg[a]),
            .den     (den_b_reg[a]),
            .neg     (smin_b_reg[a]),
            .quo     (qmin[a])
        );

        rbst_div u_div_max (
            .clk     (clk),
            .num_mag (nmax_b_reg[a]),
            .den     (den_b_reg[a]),
            .neg     (smax_b_reg[a]),
            .quo     (qmax[a])
        );
    end

    assign side_b_next = {va_reg, active_b, inslab_b};

    // Carry control beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_LAT; s++)
                side_reg[s] <= '0;
        end
        else
        begin
            side_reg[0] <= side_b_next;
            for (int s = 1; s <= DIV_LAT; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // Order each slab and clamp to the starting interval
    for (genvar a = 0; a < AXES; a++)
    begin : g_order
        logic signed [T_W-1:0] tl;
        logic signed [T_W-1:0] th;

        always_comb
        begin
            tl = (qmin[a] > qmax[a]) ? qmax[a] : qmin[a];
            th = (qmin[a] > qmax[a]) ? qmin[a] : qmax[a];
        end

        always_ff @(posedge clk)
        begin
            lo_c_reg[a] <= (side_reg[DIV_LAT].active[a] && tl > 0) ? tl : '0;
            hi_c_reg[a] <= side_reg[DIV_LAT].active[a] ? th : T_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg  <= 1'b0;
            okc_reg <= 1'b0;
        end
        else
        begin
            vc_reg  <= side_reg[DIV_LAT].valid;
            okc_reg <= &(side_reg[DIV_LAT].active | side_reg[DIV_LAT].inslab);
        end
    end

    // Narrow the interval and test it
    always_comb
    begin
        lo_d = lo_c_reg[0];
        hi_d = hi_c_reg[0];
        for (int a = 1; a < AXES; a++)
        begin
            if (lo_c_reg[a] > lo_d)
                lo_d = lo_c_reg[a];
            if (hi_c_reg[a] < hi_d)
                hi_d = hi_c_reg[a];
        end
        hit_next = okc_reg &&
                   ((T_W+1)'(lo_d) <= (T_W+1)'(hi_d) +
                    $signed({1'b0, {(T_W-EPS_W){1'b0}}, eps_reg}));
    end

    // Drive the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        entry_reg <= hit_next ? lo_d[ENTRY_W-1:0] : '0;
    end

    assign strobe     = strobe_reg;
    assign hit        = hit_reg;
    assign entry_time = entry_reg;

endmodule

/* hdl/rbst_checker.sv */
`include "ray_box_slab_test_assert.svh"

module rbst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          cfg_ready,
    input logic                          strobe,
    input logic                          hit,
    input logic [rbst_pkg::ENTRY_W-1:0]  entry_time
);
    import rbst_pkg::*;

    // A miss carries no entry time
    `RBST_ASSERT_SAME(a_miss_zero, clk, rst_n, strobe && !hit, entry_time == '0)
    // Every result comes from a transaction that was taken earlier
    `RBST_ASSERT_SAME(a_latency, clk, rst_n, strobe, $past(start && !busy, 39))
    // Once out of reset the block takes a transaction every cycle
    `RBST_ASSERT_NEXT(a_no_busy, clk, rst_n, !busy, !busy)
    // The configuration port is open whenever the input side is
    `RBST_ASSERT_SAME(a_cfg_open, clk, rst_n, !busy, cfg_ready)

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .strobe     (strobe),
    .hit        (hit),
    .entry_time (entry_time)
);

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbst_pkg::*;

    localparam int LATENCY = 39;

    typedef struct packed {
        logic signed [T_W-1:0] org_x, org_y, org_z;
        logic signed [T_W-1:0] d_x, d_y, d_z;
        logic signed [T_W-1:0] xmin, xmax, ymin, ymax, zmin, zmax;
    } ray_box_t;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry;
    } hit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [EPS_W-1:0] cfg_data = '0;
    ray_box_t item = '0;
    logic strobe;
    logic hit;
    logic [ENTRY_W-1:0] entry_time;

    logic [EPS_W-1:0] eps_model = 16'd1;
    hit_result_t expected_hits[$];
    int mismatches = 0;

    always #2 clk = ~clk;

    ray_box_slab_test uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .origin_x(item.org_x), .origin_y(item.org_y), .origin_z(item.org_z),
        .dir_x(item.d_x), .dir_y(item.d_y), .dir_z(item.d_z),
        .box_x_min(item.xmin), .box_x_max(item.xmax),
        .box_y_min(item.ymin), .box_y_max(item.ymax),
        .box_z_min(item.zmin), .box_z_max(item.zmax),
        .strobe(strobe), .hit(hit), .entry_time(entry_time)
    );

    // Saturated slab crossing time (bound - org) * 2^16 / dir
    function automatic longint crossing_time(longint bound, longint org, longint d);
        longint q;
        q = ((bound - org) * 65536) / d;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic hit_result_t predict_hit(ray_box_t r, logic [EPS_W-1:0] e);
        longint eps, lo, hi, o, d, bmin, bmax, a, b, s, mag;
        bit ok;
        hit_result_t res;
        eps = e;
        lo = 0;
        hi = 64'sd2147483647;
        ok = 1;
        for (int ax = 0; ax < 3; ax++) begin
            case (ax)
                0: begin o = r.org_x; d = r.d_x; bmin = r.xmin; bmax = r.xmax; end
                1: begin o = r.org_y; d = r.d_y; bmin = r.ymin; bmax = r.ymax; end
                default: begin o = r.org_z; d = r.d_z; bmin = r.zmin; bmax = r.zmax; end
            endcase
            if (ok) begin
                mag = d < 0 ? -d : d;
                if (mag > eps) begin
                    a = crossing_time(bmin, o, d);
                    b = crossing_time(bmax, o, d);
                    if (a > b) begin s = a; a = b; b = s; end
                    if (a > lo) lo = a;
                    if (b < hi) hi = b;
                end else if (!(o >= bmin - eps && o <= bmax + eps)) begin
                    ok = 0;
                end
            end
        end
        if (ok && lo <= hi + eps) begin
            res.hit = 1'b1;
            res.entry = lo[ENTRY_W-1:0];
        end else begin
            res = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Drive one ray transaction after the given gap; start stays high after it
    task automatic drive_ray(ray_box_t r, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_hits.push_back(predict_hit(r, eps_model));
    endtask

    // Send one ray transaction after a random gap
    task automatic send_ray(ray_box_t r);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        drive_ray(r, gap);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        wait_drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        eps_model = v;
    endtask

    // Check each result strobe against the oldest prediction
    always @(posedge clk) begin
        hit_result_t want;
        if (rst_n && strobe) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = expected_hits.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %b expected %b", hit, want.hit));
                if (entry_time !== want.entry)
                    report_mismatch($sformatf("entry_time %h expected %h",
                                              entry_time, want.entry));
            end
        end
    end

    function automatic logic [T_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? T_MAX : T_MIN;
            2: return $urandom_range(0, 8) - 4;
            default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        endcase
    endfunction

    // Mostly well-formed boxes and a random ray; a third are fully random
    function automatic ray_box_t rand_ray();
        ray_box_t r;
        logic signed [T_W-1:0] c0, c1;
        r.org_x = rand_coord(); r.org_y = rand_coord(); r.org_z = rand_coord();
        r.d_x = rand_coord(); r.d_y = rand_coord(); r.d_z = rand_coord();
        if ($urandom_range(0, 3) == 0) r.d_y = $urandom_range(0, 6) - 3;
        c0 = rand_coord(); c1 = rand_coord();
        r.xmin = (c0 < c1 || $urandom_range(0, 9) == 0) ? c0 : c1;
        r.xmax = (r.xmin == c0) ? c1 : c0;
        c0 = rand_coord(); c1 = rand_coord();
        r.ymin = c0 < c1 ? c0 : c1; r.ymax = c0 < c1 ? c1 : c0;
        c0 = rand_coord(); c1 = rand_coord();
        r.zmin = c0 < c1 ? c0 : c1; r.zmax = c0 < c1 ? c1 : c0;
        if ($urandom_range(0, 2) == 0) begin
            // Full 32-bit content on every field
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        return r;
    endfunction

    function automatic ray_box_t unit_box_ray(int dx, int dy, int dz);
        ray_box_t r;
        r.org_x = -32'sh00050000; r.org_y = 32'sh00008000; r.org_z = 32'sh00008000;
        r.d_x = dx; r.d_y = dy; r.d_z = dz;
        r.xmin = 0; r.xmax = 32'sh00010000;
        r.ymin = 0; r.ymax = 32'sh00010000;
        r.zmin = 0; r.zmax = 32'sh00010000;
        return r;
    endfunction

    task automatic test_directed();
        ray_box_t r;
        send_ray(unit_box_ray(32'sh00010000, 0, 0));        // plain hit
        send_ray(unit_box_ray(-32'sh00010000, 0, 0));       // pointing away
        send_ray(unit_box_ray(1, 0, 0));                    // near-zero dir at eps
        send_ray(unit_box_ray(2, 1, -1));                   // tiny dir, huge time
        r = unit_box_ray(32'sh00010000, 0, 0);
        r.org_y = -1; send_ray(r);                          // just outside by eps
        r.org_y = -2; send_ray(r);
        r.ymin = 32'sh00010000; r.ymax = 0; send_ray(r);    // swapped bounds
        r = unit_box_ray(32'sh00010000, 32'sh00010000, 0);
        r.org_y = -32'sh00050001; send_ray(r);              // touching interval
        send_ray({12{T_MAX}});
        send_ray({12{T_MIN}});
        r = {12{T_MIN}}; r.d_x = T_MAX; r.xmax = T_MAX; send_ray(r);
        r = {12{T_MAX}}; r.d_z = T_MIN; r.zmin = T_MIN; send_ray(r);
        send_ray('0);
        send_ray({12{32'hFFFFFFFF}});
        r = unit_box_ray(T_MIN, T_MAX, 32'sh00000100); send_ray(r);
    endtask

    task automatic test_epsilon_settings();
        logic [EPS_W-1:0] settings[4] = '{16'd0, 16'hFFFF, 16'h0100, 16'd1};
        foreach (settings[i]) begin
            write_epsilon(settings[i]);
            send_ray(unit_box_ray(32'sh00010000, 0, 0));
            send_ray(unit_box_ray(16'hFFFF, 16'hFFFF, 0));
            for (int k = 0; k < 40; k++) send_ray(rand_ray());
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 480; k++) begin
            if (k == 240) wait_drain();
            if ($urandom_range(0, 3) == 0) begin
                // Back-to-back burst with no gaps
                drive_ray(rand_ray(), 0);
            end else begin
                send_ray(rand_ray());
            end
        end
        write_epsilon(EPS_W'($urandom));
        for (int k = 0; k < 20; k++) send_ray(rand_ray());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_epsilon_settings();
        test_random();
        wait_drain();
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
